// ===== hw/rtl/ptw_pkg.sv =====
// Shared types and constants for the three-level page table walker.
package ptw_pkg;

  localparam int unsigned PAGE_SHIFT = 13;
  localparam int unsigned VIRT_BITS  = 43;
  localparam int unsigned ADDR_W     = 45;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned PIDX_W     = 3 * IDX_W;
  localparam int unsigned TOP_W      = 64 - VIRT_BITS;

  // PTE bit positions
  localparam int unsigned PTE_V      = 0;
  localparam int unsigned PTE_FOR    = 1;
  localparam int unsigned PTE_FOE    = 3;
  localparam int unsigned PTE_KRE    = 8;
  localparam int unsigned PTE_KWE    = 12;
  localparam int unsigned PTE_PFN_LO = 32;

  typedef enum logic [0:0] {
    REQ_XLATE = 1'b0,
    REQ_PTE   = 1'b1
  } req_e;

  typedef enum logic [0:0] {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    FC_OK    = 3'd0,
    FC_ACV   = 3'd1,
    FC_NV    = 3'd2,
    FC_FOR   = 3'd3,
    FC_FOW   = 3'd4,
    FC_FOE   = 3'd5
  } fault_e;

  // Walk level, one-hot
  typedef enum logic [3:0] {
    LVL_IDLE = 4'b0001,
    LVL_L1   = 4'b0010,
    LVL_L2   = 4'b0100,
    LVL_L3   = 4'b1000
  } level_e;

  typedef struct packed {
    level_e              level;
    logic [PIDX_W-1:0]   page_idx;
    logic [2:0]          need;
    logic [1:0]          mode;
  } walk_t;

  typedef struct packed {
    logic              out_kind;
    logic [ADDR_W-1:0] read_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic [2:0]        prot_bits;
    logic [2:0]        fault_code;
  } res_t;

endpackage

// ===== hw/rtl/three_level_page_table_walker_core.sv =====
// A result beat is registered in the output buffer before it is offered.
// Throughput: one input beat per cycle; the walk state and a two-entry output
// buffer (output register plus skid entry) set the rate, and a full buffer stalls input.
// Reset (async, active low): walk idle, saved walk fields and table base cleared,
// output buffer empty.
// Top level: walk state registers, table base register and result buffer.
module three_level_page_table_walker_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ptw_pkg::ADDR_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       req_type_i,
  input  logic [63:0]                virt_addr_i,
  input  logic [2:0]                 access_need_i,
  input  logic [1:0]                 mode_index_i,
  input  logic [63:0]                pte_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       out_kind_o,
  output logic [ptw_pkg::ADDR_W-1:0] read_addr_o,
  output logic [ptw_pkg::ADDR_W-1:0] phys_addr_o,
  output logic [2:0]                 prot_bits_o,
  output logic [2:0]                 fault_code_o
);
  import ptw_pkg::*;

  walk_t             walk_q, walk_d;
  logic [ADDR_W-1:0] table_base_q;
  logic              res_valid;
  res_t              res;
  res_t              out_data;
  logic              buf_ready;
  logic              in_beat;

  assign in_ready_o = buf_ready;
  assign in_beat    = in_valid_i && buf_ready;

  ptw_step u_step (
    .walk_i        (walk_q),
    .table_base_i  (table_base_q),
    .req_type_i    (req_type_i),
    .virt_addr_i   (virt_addr_i),
    .access_need_i (access_need_i),
    .mode_index_i  (mode_index_i),
    .pte_data_i    (pte_data_i),
    .walk_o        (walk_d),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Hold walk state, advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '{level: LVL_IDLE, page_idx: '0, need: '0, mode: '0};
    end else if (in_beat) begin
      walk_q <= walk_d;
    end
  end

  // Table base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_base_q <= '0;
    end else if (cfg_we_i) begin
      table_base_q <= cfg_wdata_i;
    end
  end

  ptw_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_beat && res_valid),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign out_kind_o   = out_data.out_kind;
  assign read_addr_o  = out_data.read_addr;
  assign phys_addr_o  = out_data.phys_addr;
  assign prot_bits_o  = out_data.prot_bits;
  assign fault_code_o = out_data.fault_code;

endmodule

// ===== hw/rtl/ptw_step.sv =====
// Combinational walk step: one request or PTE beat against the walk state.
module ptw_step (
  input  ptw_pkg::walk_t            walk_i,
  input  logic [ptw_pkg::ADDR_W-1:0] table_base_i,
  input  logic                      req_type_i,
  input  logic [63:0]               virt_addr_i,
  input  logic [2:0]                access_need_i,
  input  logic [1:0]                mode_index_i,
  input  logic [63:0]               pte_data_i,
  output ptw_pkg::walk_t            walk_o,
  output logic                      res_valid_o,
  output ptw_pkg::res_t             res_o
);
  import ptw_pkg::*;

  logic [TOP_W-1:0]  top;
  logic              bad_sext;
  logic              superpage;
  logic [ADDR_W-1:0] super_phys;
  logic [PIDX_W-1:0] new_pidx;
  logic [ADDR_W-1:0] frame;
  logic [IDX_W-1:0]  next_idx;
  logic [ADDR_W-1:0] idx_off;
  logic [ADDR_W-1:0] l1_addr;
  logic [ADDR_W-1:0] next_addr;
  logic [3:0]        kre_bits;
  logic [3:0]        kwe_bits;
  logic [2:0]        prot0;
  logic [2:0]        prot1;
  fault_e            fo_code;

  // Decode the translate request
  assign top        = virt_addr_i[63:VIRT_BITS];
  assign bad_sext   = (top != '0) && (top != '1);
  assign superpage  = virt_addr_i[63] && (virt_addr_i[42:41] == 2'b10);
  assign super_phys = {1'b0, virt_addr_i[40], 3'b000, virt_addr_i[39:0]};
  assign new_pidx   = virt_addr_i[PAGE_SHIFT +: PIDX_W];
  assign l1_addr    = table_base_i + ADDR_W'({new_pidx[2*IDX_W +: IDX_W], 3'b000});

  // Decode the returned PTE
  assign frame     = ADDR_W'(pte_data_i[63:PTE_PFN_LO]) << PAGE_SHIFT;
  assign next_idx  = walk_i.level[1] ? walk_i.page_idx[IDX_W +: IDX_W]
                                     : walk_i.page_idx[0 +: IDX_W];
  assign idx_off   = ADDR_W'({next_idx, 3'b000});
  assign next_addr = frame + idx_off;
  assign kre_bits  = pte_data_i[PTE_KRE +: 4];
  assign kwe_bits  = pte_data_i[PTE_KWE +: 4];
  assign prot0     = {kre_bits[walk_i.mode], kwe_bits[walk_i.mode], kre_bits[walk_i.mode]};
  assign prot1     = prot0 & ~pte_data_i[PTE_FOE:PTE_FOR];

  // Pick the fault-on code, execute first
  always_comb begin
    if (walk_i.need[2]) begin
      fo_code = FC_FOE;
    end else if (walk_i.need[1]) begin
      fo_code = FC_FOW;
    end else begin
      fo_code = FC_FOR;
    end
  end

  // Work out next state and result
  always_comb begin
    walk_o      = walk_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.out_kind = KIND_DONE;
    if (req_type_i == REQ_XLATE) begin
      res_valid_o  = 1'b1;
      walk_o.level = LVL_IDLE;
      if (bad_sext) begin
        res_o.fault_code = FC_ACV;
      end else if (superpage) begin
        if (mode_index_i != 2'd0) begin
          res_o.fault_code = FC_ACV;
        end else begin
          res_o.phys_addr = super_phys;
          res_o.prot_bits = 3'b111;
        end
      end else begin
        walk_o.level     = LVL_L1;
        walk_o.page_idx  = new_pidx;
        walk_o.need      = access_need_i;
        walk_o.mode      = mode_index_i;
        res_o.out_kind   = KIND_READ;
        res_o.read_addr  = l1_addr;
      end
    end else begin
      case (walk_i.level)
        LVL_L1, LVL_L2: begin
          res_valid_o = 1'b1;
          if (!pte_data_i[PTE_V]) begin
            walk_o.level     = LVL_IDLE;
            res_o.fault_code = FC_NV;
          end else if (!pte_data_i[PTE_KRE]) begin
            walk_o.level     = LVL_IDLE;
            res_o.fault_code = FC_ACV;
          end else begin
            walk_o.level    = (walk_i.level == LVL_L1) ? LVL_L2 : LVL_L3;
            res_o.out_kind  = KIND_READ;
            res_o.read_addr = next_addr;
          end
        end
        LVL_L3: begin
          res_valid_o     = 1'b1;
          walk_o.level    = LVL_IDLE;
          res_o.phys_addr = frame;
          if (!pte_data_i[PTE_V]) begin
            res_o.fault_code = FC_NV;
          end else if ((walk_i.need != 3'd0) && ((prot0 & walk_i.need) == 3'd0)) begin
            res_o.prot_bits  = prot0;
            res_o.fault_code = FC_ACV;
          end else if ((walk_i.need != 3'd0) && ((prot1 & walk_i.need) == 3'd0)) begin
            res_o.prot_bits  = prot1;
            res_o.fault_code = fo_code;
          end else begin
            res_o.prot_bits  = prot1;
          end
        end
        default: begin
          // idle: drop stray PTE beat
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ptw_outbuf.sv =====
// Two-entry result buffer: output register plus skid entry.
module ptw_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ptw_pkg::res_t push_data_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ptw_pkg::res_t out_data_o
);
  import ptw_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic pop;
  logic to_out;

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pop         = out_valid_q && out_ready_i;
  assign to_out      = !out_valid_q || (pop && !skid_valid_q);

  // Advance the skid entry, load a new beat where there is room
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      out_valid_d  = skid_valid_q;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end
    if (push_i) begin
      if (to_out) begin
        out_valid_d = 1'b1;
        out_d       = push_data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule
